// File: src/swap_slot_allocator_pte_rewrite_defines.svh
// Assertion macros shared by the swap slot allocator RTL.
`ifndef SWAP_SLOT_ALLOCATOR_PTE_REWRITE_DEFINES_SVH
`define SWAP_SLOT_ALLOCATOR_PTE_REWRITE_DEFINES_SVH

`ifndef SYNTHESIS

// Clocked check, switched off while reset is high.
`define SSA_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ssa assertion failed");

// Clocked check that also holds through reset.
`define SSA_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ssa assertion failed");

`else

`define SSA_ASSERT(lbl, clk, rst, prop)
`define SSA_ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

// File: src/ssa_pkg.sv
// Package: constants, codes and shared types of the swap slot allocator.
package ssa_pkg;

  localparam int SLOT_COUNT      = 128;
  // must stay a power of two: block <-> slot mapping is a shift
  localparam int BLOCKS_PER_SLOT = 8;
  localparam int SLOT_W          = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int BPS_SHIFT       = $clog2(BLOCKS_PER_SLOT);

  localparam int ENTRY_W = 32;
  localparam int FLAG_W  = 12;
  localparam int BLOCK_W = ENTRY_W - FLAG_W;
  localparam int POS_W   = 4;

  localparam logic [POS_W-1:0]   FLAG_TOP     = POS_W'(FLAG_W - 1);
  localparam logic [FLAG_W-1:0]  PRESENT_MASK = FLAG_W'(1);
  // blocks covered by the whole swap area, measured from the base
  localparam logic [BLOCK_W:0]   SLOT_SPAN    = (BLOCK_W + 1)'(SLOT_COUNT * BLOCKS_PER_SLOT);

  localparam logic [BLOCK_W-1:0] BASE_RESET = BLOCK_W'(2);
  localparam logic [POS_W-1:0]   POS_RESET  = POS_W'(9);

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = BLOCK_W;

  typedef enum logic {
    OP_SWAP_OUT = 1'b0,
    OP_SWAP_IN  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_NO_SLOT     = 2'd1,
    ST_NOT_SWAPPED = 2'd2,
    ST_RANGE       = 2'd3
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SWAP_BASE = 1'b0,
    CFG_SWAP_BIT  = 1'b1
  } cfg_reg_t;

  // bitmap write request
  typedef struct packed {
    logic              set_en;
    logic              clr_en;
    logic [SLOT_W-1:0] idx;
  } slot_upd_t;

  // first-fit search result
  typedef struct packed {
    logic              found;
    logic [SLOT_W-1:0] first;
  } slot_info_t;

endpackage

// File: src/ssa_bitmap.sv
// Free-slot bitmap with first-fit encoder and single-slot update.
`include "swap_slot_allocator_pte_rewrite_defines.svh"

module ssa_bitmap (
  input  logic                clk,
  input  logic                rst,
  input  ssa_pkg::slot_upd_t  upd,
  output ssa_pkg::slot_info_t info
);

  logic [ssa_pkg::SLOT_COUNT-1:0] slot_free;
  logic [ssa_pkg::SLOT_COUNT-1:0] slot_free_next;
  logic [ssa_pkg::SLOT_COUNT-1:0] lowest;

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_free <= '1;
    end else begin
      slot_free <= slot_free_next;
    end
  end

  always_comb begin
    slot_free_next = slot_free;
    if (upd.set_en) begin
      slot_free_next[upd.idx] = 1'b1;
    end
    if (upd.clr_en) begin
      slot_free_next[upd.idx] = 1'b0;
    end
  end

  // isolate lowest free bit, then one-hot to binary
  assign lowest = slot_free & (~slot_free + {{(ssa_pkg::SLOT_COUNT-1){1'b0}}, 1'b1});

  always_comb begin
    logic acc;
    info.found = |slot_free;
    info.first = '0;
    for (int b = 0; b < ssa_pkg::SLOT_W; b++) begin
      acc = 1'b0;
      for (int j = 0; j < ssa_pkg::SLOT_COUNT; j++) begin
        if (j[b]) begin
          acc = acc | lowest[j];
        end
      end
      info.first[b] = acc;
    end
  end

  `SSA_ASSERT(a_clr_first_free, clk, rst, upd.clr_en |-> info.found && upd.idx == info.first)
  `SSA_ASSERT(a_clr_takes_one, clk, rst, upd.clr_en |=> $countones(slot_free) == $past($countones(slot_free)) - 1)
  `SSA_ASSERT(a_set_frees, clk, rst, upd.set_en |=> slot_free[$past(upd.idx)])

endmodule

// File: src/ssa_rewrite.sv
// Result logic: PTE rewrite, disk block, status and bitmap request.
module ssa_rewrite (
  input  logic                                go,
  input  logic                                op,
  input  logic [ssa_pkg::ENTRY_W-1:0]         entry_in,
  input  logic [ssa_pkg::BLOCK_W-1:0]         new_frame,
  input  logic [ssa_pkg::BLOCK_W-1:0]         swap_base,
  input  logic [ssa_pkg::POS_W-1:0]           swap_pos,
  input  ssa_pkg::slot_info_t                 info,
  output logic [ssa_pkg::ENTRY_W-1:0]         entry_out,
  output logic [ssa_pkg::BLOCK_W-1:0]         disk_block,
  output ssa_pkg::status_t                    status,
  output ssa_pkg::slot_upd_t                  upd
);

  logic [ssa_pkg::POS_W-1:0]   pos_sat;
  logic [ssa_pkg::FLAG_W-1:0]  so_mask;
  logic [ssa_pkg::FLAG_W-1:0]  flags;
  logic [ssa_pkg::BLOCK_W:0]   out_block;
  logic [ssa_pkg::BLOCK_W-1:0] in_block;
  logic [ssa_pkg::BLOCK_W-1:0] offset;
  logic [ssa_pkg::SLOT_W-1:0]  in_idx;

  assign pos_sat   = (swap_pos > ssa_pkg::FLAG_TOP) ? ssa_pkg::FLAG_TOP : swap_pos;
  assign so_mask   = ssa_pkg::PRESENT_MASK << pos_sat;
  assign flags     = entry_in[ssa_pkg::FLAG_W-1:0];
  // one spare bit catches a block number past 20 bits
  assign out_block = {1'b0, swap_base}
                   + ((ssa_pkg::BLOCK_W + 1)'(info.first) << ssa_pkg::BPS_SHIFT);
  assign in_block  = entry_in[ssa_pkg::ENTRY_W-1:ssa_pkg::FLAG_W];
  assign offset    = in_block - swap_base;
  assign in_idx    = ssa_pkg::SLOT_W'(offset >> ssa_pkg::BPS_SHIFT);

  always_comb begin
    entry_out  = entry_in;
    disk_block = '0;
    status     = ssa_pkg::ST_OK;
    upd        = '0;
    case (ssa_pkg::op_t'(op))
      ssa_pkg::OP_SWAP_OUT: begin
        if (!info.found) begin
          status = ssa_pkg::ST_NO_SLOT;
        end else if (out_block[ssa_pkg::BLOCK_W]) begin
          status = ssa_pkg::ST_RANGE;
        end else begin
          entry_out  = {out_block[ssa_pkg::BLOCK_W-1:0],
                        (flags & ~ssa_pkg::PRESENT_MASK) | so_mask};
          disk_block = out_block[ssa_pkg::BLOCK_W-1:0];
          upd.clr_en = go;
          upd.idx    = info.first;
        end
      end
      ssa_pkg::OP_SWAP_IN: begin
        if ((flags & so_mask) == '0) begin
          status = ssa_pkg::ST_NOT_SWAPPED;
        end else if (in_block < swap_base) begin
          status = ssa_pkg::ST_RANGE;
        end else if ({1'b0, offset} >= ssa_pkg::SLOT_SPAN) begin
          status = ssa_pkg::ST_RANGE;
        end else begin
          entry_out  = {new_frame, (flags & ~so_mask) | ssa_pkg::PRESENT_MASK};
          disk_block = in_block;
          upd.set_en = go;
          upd.idx    = in_idx;
        end
      end
      default: begin
        status = ssa_pkg::ST_OK;
      end
    endcase
  end

endmodule

// File: src/swap_slot_allocator_pte_rewrite.sv
// Swap slot allocator with PTE rewrite: one request beat in, one result beat out.
// A swap-out takes the lowest free slot of a 128-entry bitmap (all free after
// reset), marks it used and returns the PTE with the slot's disk block in bits
// 31..12, present cleared and the swapped-out flag set; a swap-in checks that
// flag, frees the slot named by bits 31..12 and returns the new frame with the
// flags turned back. Errors (no free slot, entry not swapped out, block out of
// range) give the entry unchanged, disk block zero and leave the bitmap alone.
// A request beat lands in an input register; as it moves into the result
// register the bitmap is searched, the result formed and the bitmap updated in
// one pass. One beat per cycle is sustained while the result channel does not
// stall. The user must write configuration (swap base block, swapped-out flag
// position) only while no request is in flight; the block does not enforce
// this, and the port always takes a write.
`include "swap_slot_allocator_pte_rewrite_defines.svh"

module swap_slot_allocator_pte_rewrite (
  input  logic                              clk,
  input  logic                              rst,
  // request channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [ssa_pkg::ENTRY_W-1:0]       entry_in,
  input  logic [ssa_pkg::BLOCK_W-1:0]       new_frame,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ssa_pkg::ENTRY_W-1:0]       entry_out,
  output logic [ssa_pkg::BLOCK_W-1:0]       disk_block,
  output logic [1:0]                        status,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ssa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // configuration registers
  logic [ssa_pkg::BLOCK_W-1:0] swap_base;
  logic [ssa_pkg::POS_W-1:0]   swap_pos;

  // input register
  logic                        s1_valid;
  logic                        s1_op;
  logic [ssa_pkg::ENTRY_W-1:0] s1_entry;
  logic [ssa_pkg::BLOCK_W-1:0] s1_frame;

  logic                        advance;
  ssa_pkg::slot_info_t         info;
  ssa_pkg::slot_upd_t          upd;
  logic [ssa_pkg::ENTRY_W-1:0] res_entry;
  logic [ssa_pkg::BLOCK_W-1:0] res_block;
  ssa_pkg::status_t            res_status;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      swap_base <= ssa_pkg::BASE_RESET;
      swap_pos  <= ssa_pkg::POS_RESET;
    end else if (cfg_valid) begin
      case (ssa_pkg::cfg_reg_t'(cfg_index))
        ssa_pkg::CFG_SWAP_BASE: swap_base <= cfg_data;
        ssa_pkg::CFG_SWAP_BIT:  swap_pos  <= cfg_data[ssa_pkg::POS_W-1:0];
        default: begin
          swap_base <= swap_base;
        end
      endcase
    end
  end

  // stage 1 moves on when the result register is empty or being drained
  assign advance  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_op    <= op;
      s1_entry <= entry_in;
      s1_frame <= new_frame;
    end
  end

  ssa_bitmap u_bitmap (
    .clk  (clk),
    .rst  (rst),
    .upd  (upd),
    .info (info)
  );

  // bitmap write is gated by advance so a stalled beat changes nothing
  ssa_rewrite u_rewrite (
    .go         (advance),
    .op         (s1_op),
    .entry_in   (s1_entry),
    .new_frame  (s1_frame),
    .swap_base  (swap_base),
    .swap_pos   (swap_pos),
    .info       (info),
    .entry_out  (res_entry),
    .disk_block (res_block),
    .status     (res_status),
    .upd        (upd)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      entry_out  <= res_entry;
      disk_block <= res_block;
      status     <= res_status;
    end
  end

  `SSA_ASSERT(a_advance_fills_out, clk, rst, advance |=> out_valid)
  `SSA_ASSERT(a_stall_holds_s1, clk, rst, s1_valid && !advance |=> s1_valid && $stable(s1_entry))
  `SSA_ASSERT(a_no_overwrite, clk, rst, out_valid && !out_ready |-> !advance)

endmodule
